[src/rdc_pkg.sv]
// rdc_pkg: shared constants and controller/datapath interface types
// for the radix digit converter. No dependencies.
`default_nettype none

package rdc_pkg;

	// binary word that carries a packed decimal number
	localparam int WORD_W  = 60;
	// stream bus width, word padded to whole bytes
	localparam int TDATA_W = 64;
	// one decimal digit
	localparam int DIG_W   = 4;
	// decimal digits needed for any 60-bit value
	localparam int NUM_DEC = 19;
	// default count of result digits
	localparam int DIGITS_DEF = 18;
	// step counter, large enough for one pass over the word bits
	localparam int CNT_W   = $clog2(WORD_W);

	// base register width and limits
	localparam int BASE_W = 4;
	localparam logic [BASE_W-1:0] BASE_MIN  = 4'd2;
	localparam logic [BASE_W-1:0] BASE_MAX  = 4'd10;
	localparam logic [BASE_W-1:0] RADIX_TEN = 4'd10;
	localparam logic [BASE_W-1:0] FROM_RST  = 4'd10;
	localparam logic [BASE_W-1:0] TO_RST    = 4'd2;

	// configuration register indexes
	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_FROM_BASE = 1'b0;
	localparam logic [IDX_W-1:0] REG_TO_BASE   = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;     // take a new item, clear digits and flags
		logic dbl;      // shift one word bit into the digit register
		logic to_dst;   // doubling in the target base (else base ten)
		logic mac;      // word = word * mult + top digit, digits shift up
		logic weigh;    // multiply by the source base (else by ten)
		logic check;    // latch the digit validity check
		logic out_load; // move the result into the output register
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic bad_now;  // some decimal digit is not below the source base
	} dp_status_t;

endpackage

`default_nettype wire

[src/rdc_ctrl.sv]
// rdc_ctrl: sequencer for the radix digit converter; steps the datapath
// through its phases and owns both stream handshakes. Uses rdc_pkg.
`default_nettype none

module rdc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output rdc_pkg::dp_cmd_t         cmd,
	input  wire rdc_pkg::dp_status_t status
);
	import rdc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_TO_DEC = 7'b0000010,
		ST_CHECK  = 7'b0000100,
		ST_WEIGH  = 7'b0001000,
		ST_TO_DST = 7'b0010000,
		ST_PACK   = 7'b0100000,
		ST_FLUSH  = 7'b1000000
	} state_t;

	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_W - 1);
	localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(NUM_DEC - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_vld_q, out_vld_d;

	// next state, step count and datapath commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_TO_DEC;
				end
			end
			ST_TO_DEC: begin
				cmd.dbl = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cnt_d     = '0;
				state_d   = status.bad_now ? ST_FLUSH : ST_WEIGH;
			end
			ST_WEIGH: begin
				cmd.mac   = 1'b1;
				cmd.weigh = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == LAST_DIG) begin
					cnt_d   = '0;
					state_d = ST_TO_DST;
				end
			end
			ST_TO_DST: begin
				cmd.dbl    = 1'b1;
				cmd.to_dst = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					cnt_d   = '0;
					state_d = ST_PACK;
				end
			end
			ST_PACK: begin
				cmd.mac = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == LAST_DIG) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!out_vld_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register occupancy
	always_comb begin
		if (cmd.out_load) begin
			out_vld_d = 1'b1;
		end else if (m_tready) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			out_vld_q <= out_vld_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

`ifndef ASSERT_OFF
	// a result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || m_tready))
		else $error("result loaded over a waiting result");

	// an accepted item starts the decimal pass from step zero
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_TO_DEC && cnt_q == '0))
		else $error("accepted item did not start conversion");

	// no datapath work while the input side is open
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.dbl || cmd.mac || cmd.check))
		else $error("datapath busy while idle");
`endif

endmodule

`default_nettype wire

[src/rdc_datapath.sv]
// rdc_datapath: base registers, word shift register, digit register with
// base-n doubling, multiply-add unit and output register. Uses rdc_pkg.
`default_nettype none

module rdc_datapath #(
	parameter int DIGITS = rdc_pkg::DIGITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [rdc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [rdc_pkg::BASE_W-1:0] cfg_data,
	input  wire logic [rdc_pkg::WORD_W-1:0] digits_in,
	input  wire rdc_pkg::dp_cmd_t           cmd,
	output rdc_pkg::dp_status_t             status,
	output logic [rdc_pkg::WORD_W-1:0]      digits_out,
	output logic                            bad_digit,
	output logic                            too_long
);
	import rdc_pkg::*;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end
		return r;
	endfunction

	logic [BASE_W-1:0]               from_base_q, to_base_q;
	logic [BASE_W-1:0]               src_base, dst_base, dbl_base, mult;
	logic [WORD_W-1:0]               word_q, mac_word;
	logic [WORD_W+DIG_W-1:0]         prod;
	logic [NUM_DEC-1:0][DIG_W-1:0]   dig_q, dbl_dig, shl_dig;
	logic [NUM_DEC-1:0]              gen, prop;
	logic [NUM_DEC:0]                dbl_sum, carry;
	logic                            bad_q, long_q;
	logic [WORD_W-1:0]               out_data_q;
	logic                            out_bad_q, out_long_q;

	assign cfg_ready = 1'b1;
	assign src_base  = clamp_base(from_base_q);
	assign dst_base  = clamp_base(to_base_q);
	assign dbl_base  = cmd.to_dst ? dst_base : RADIX_TEN;
	assign mult      = cmd.weigh ? src_base : RADIX_TEN;

	// per-digit carry generate/propagate for doubling in base dbl_base:
	// generate when 2d >= base, propagate when 2d + 1 == base (odd base)
	always_comb begin
		for (int k = 0; k < NUM_DEC; k++) begin
			gen[k]  = ({dig_q[k], 1'b0} >= {1'b0, dbl_base});
			prop[k] = ({dig_q[k], 1'b1} == {1'b0, dbl_base});
		end
	end

	// carries resolved by one adder: a = g|p, b = g, so a&b = g and a^b = p
	assign dbl_sum = {1'b0, gen | prop} + {1'b0, gen} + (NUM_DEC+1)'(word_q[WORD_W-1]);
	assign carry   = dbl_sum ^ {1'b0, gen | prop} ^ {1'b0, gen};

	// new digits after doubling; in the target-base pass, digits past the result length stay clear
	always_comb begin
		logic [DIG_W:0] tval;
		logic [DIG_W:0] diff;
		for (int k = 0; k < NUM_DEC; k++) begin
			tval = {dig_q[k], carry[k]};
			diff = tval - {1'b0, dbl_base};
			dbl_dig[k] = carry[k+1] ? diff[DIG_W-1:0] : tval[DIG_W-1:0];
			if (cmd.to_dst && (k >= DIGITS)) begin
				dbl_dig[k] = '0;
			end
		end
	end

	// multiply-add with the top digit, digits move up by one place
	assign prod     = word_q * mult;
	assign mac_word = prod[WORD_W-1:0] + WORD_W'(dig_q[NUM_DEC-1]);
	assign shl_dig  = {dig_q[NUM_DEC-2:0], DIG_W'(0)};

	// validity check of the decimal digits against the source base
	always_comb begin
		status.bad_now = 1'b0;
		for (int k = 0; k < NUM_DEC; k++) begin
			if (dig_q[k] >= src_base) begin
				status.bad_now = 1'b1;
			end
		end
	end

	// word shift register and accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= digits_in;
		end else if (cmd.dbl) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
		end else if (cmd.mac) begin
			word_q <= mac_word;
		end
	end

	// base registers, digit register, flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_base_q <= FROM_RST;
			to_base_q   <= TO_RST;
			dig_q       <= '0;
			bad_q       <= 1'b0;
			long_q      <= 1'b0;
			out_data_q  <= '0;
			out_bad_q   <= 1'b0;
			out_long_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FROM_BASE: from_base_q <= cfg_data;
					REG_TO_BASE:   to_base_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				dig_q  <= '0;
				bad_q  <= 1'b0;
				long_q <= 1'b0;
			end else begin
				if (cmd.dbl) begin
					dig_q <= dbl_dig;
				end else if (cmd.mac) begin
					dig_q <= shl_dig;
				end
				if (cmd.check) begin
					bad_q <= status.bad_now;
				end
				if (cmd.dbl && cmd.to_dst && carry[DIGITS]) begin
					long_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_data_q <= (bad_q || long_q) ? '0 : word_q;
				out_bad_q  <= bad_q;
				out_long_q <= long_q;
			end
		end
	end

	assign digits_out = out_data_q;
	assign bad_digit  = out_bad_q;
	assign too_long   = out_long_q;

`ifndef ASSERT_OFF
	// nineteen decimal digits always hold a 60-bit word
	a_dec_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dbl && !cmd.to_dst) |-> !carry[NUM_DEC])
		else $error("decimal digit register overflowed");

	// overflow is only reached when the digits were valid
	a_long_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		long_q |-> !bad_q)
		else $error("overflow flagged on a bad item");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(bad_digit || too_long) |-> (digits_out == '0))
		else $error("error result with nonzero value");
`endif

endmodule

`default_nettype wire

[src/radix_digit_converter.sv]
// Radix digit converter: one item in, one result out, one item at a time.
// Steps from input accept to result valid (a bad digit skips to the output load):
// 60 base-ten doubling steps, 1 check, 19 weighing steps, 60 target-base
// doubling steps, 19 packing steps, 1 output load; a new item is taken only
// after the output load, which waits while a previous result is still held.
// Reset (arst_n low, asynchronous) returns to idle with from_base 10, to_base 2.
`default_nettype none

module radix_digit_converter #(
	parameter int DIGITS = rdc_pkg::DIGITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rdc_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [rdc_pkg::BASE_W-1:0]  cfg_data,
	// input items
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [rdc_pkg::TDATA_W-1:0] s_tdata,  // [59:0] digits_in, [63:60] zero
	// result items
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [rdc_pkg::TDATA_W-1:0]      m_tdata,  // [59:0] digits_out, [63:60] zero
	output logic [1:0]                       m_tuser   // [0] bad_digit, [1] too_long
);
	import rdc_pkg::*;

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic [WORD_W-1:0] digits_out;
	logic              bad_digit, too_long;

	// sequencer
	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// arithmetic and storage
	rdc_datapath #(
		.DIGITS (DIGITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.digits_in  (s_tdata[WORD_W-1:0]),
		.cmd        (cmd),
		.status     (status),
		.digits_out (digits_out),
		.bad_digit  (bad_digit),
		.too_long   (too_long)
	);

	// result packing onto the bus
	assign m_tdata = {(TDATA_W-WORD_W)'(0), digits_out};
	assign m_tuser = {too_long, bad_digit};

endmodule

`default_nettype wire

[test/radix_digit_converter_checker.sv]
// radix_digit_converter_checker: watches the config, input and result channels
// of the radix digit converter, predicts each result and compares it.
// Depends on rdc_pkg for widths, base limits and register indexes.
`default_nettype none

module radix_digit_converter_checker #(
	parameter int DIGITS = rdc_pkg::DIGITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire logic                        cfg_ready,
	input  wire logic [rdc_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [rdc_pkg::BASE_W-1:0]  cfg_data,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [rdc_pkg::TDATA_W-1:0] s_tdata,  // [59:0] digits_in, [63:60] zero
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [rdc_pkg::TDATA_W-1:0] m_tdata,  // [59:0] digits_out, [63:60] zero
	input  wire logic [1:0]                  m_tuser,  // [0] bad_digit, [1] too_long
	output int                               pending,
	output int                               errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import rdc_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam int PAD_W = TDATA_W - WORD_W;

	typedef struct packed {
		logic [WORD_W-1:0] din;
		logic [WORD_W-1:0] digits;
		logic              bad;
		logic              longer;
	} conversion_t;

	// local copy of the base registers
	logic [BASE_W-1:0] from_base;
	logic [BASE_W-1:0] to_base;
	conversion_t       conv_q[$];
	int                mismatches = 0;

	// weigh the decimal digits by the source base, then split by the target base
	function automatic conversion_t convert_digits(logic [WORD_W-1:0] din,
			logic [BASE_W-1:0] from_raw, logic [BASE_W-1:0] to_raw);
		logic [63:0] src, dst, num, value, weight, result, place, d;
		int unsigned count;
		conversion_t c;
		src = (from_raw < BASE_MIN) ? 64'(BASE_MIN) :
			(from_raw > BASE_MAX) ? 64'(BASE_MAX) : 64'(from_raw);
		dst = (to_raw < BASE_MIN) ? 64'(BASE_MIN) :
			(to_raw > BASE_MAX) ? 64'(BASE_MAX) : 64'(to_raw);
		num = 64'(din);
		value = 0;
		weight = 1;
		result = 0;
		place = 1;
		count = 0;
		c.din = din;
		c.bad = 1'b0;
		c.longer = 1'b0;
		while (num != 0) begin
			d = num % 10;
			if (d >= src)
				c.bad = 1'b1;
			value += d * weight;
			weight *= src;
			num /= 10;
		end
		// a bad digit skips the conversion altogether
		if (!c.bad) begin
			while (value != 0) begin
				if (count >= DIGITS) begin
					c.longer = 1'b1;
					break;
				end
				result += (value % dst) * place;
				place *= 10;
				value /= dst;
				count++;
			end
		end
		c.digits = (c.bad || c.longer) ? '0 : result[WORD_W-1:0];
		return c;
	endfunction

	// follow config writes, queue predictions, match results in order
	always @(posedge clk or negedge arst_n) begin
		conversion_t want;
		if (!arst_n) begin
			from_base <= FROM_RST;
			to_base   <= TO_RST;
			pending   <= 0;
			errors    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FROM_BASE: from_base <= cfg_data;
					REG_TO_BASE:   to_base   <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				conv_q.push_back(convert_digits(s_tdata[WORD_W-1:0], from_base, to_base));
			if (m_tvalid && m_tready) begin
				if (conv_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result item: digits_out %0d bad_digit %0b too_long %0b",
							m_tdata, m_tuser[0], m_tuser[1]);
				end else begin
					want = conv_q.pop_front();
					if (m_tdata !== {{PAD_W{1'b0}}, want.digits} || m_tuser[0] !== want.bad
							|| m_tuser[1] !== want.longer) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"mismatch for digits_in %0d: expected %0d/%0b/%0b,",
								" got %0d/%0b/%0b (digits_out/bad_digit/too_long)"},
								want.din, want.digits, want.bad, want.longer,
								m_tdata, m_tuser[0], m_tuser[1]);
					end
				end
			end
			pending <= conv_q.size();
			errors  <= mismatches;
		end
	end

endmodule

`default_nettype wire

[test/radix_digit_converter_tb.sv]
// radix_digit_converter_tb: drives base settings and digit items into the radix
// digit converter with bursty input and a stalling receiver, and gives the verdict.
// Depends on rdc_pkg, radix_digit_converter and radix_digit_converter_checker.
`default_nettype none

module radix_digit_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rdc_pkg::*;

	localparam int          CLK_HALF      = 4;
	localparam int          RESET_CYCLES  = 12;
	localparam int          RANDOM_PHASES = 12;
	localparam int          PHASE_ITEMS   = 120;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          DRAIN_CYCLES  = 200;
	localparam int unsigned CYCLE_LIMIT   = 4_000_000;
	localparam logic [63:0] WORD_MASK     = (64'd1 << WORD_W) - 1;
	localparam logic [63:0] TEN_POW_18    = 64'd1_000_000_000_000_000_000;

	typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY } rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index;
	logic [BASE_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;   // [59:0] digits_in, [63:60] zero
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // [59:0] digits_out, [63:60] zero
	logic [1:0]           m_tuser;   // [0] bad_digit, [1] too_long
	int                   pending;
	int                   errors;
	int unsigned          src_base;  // effective source base for stimulus

	radix_digit_converter dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	radix_digit_converter_checker checker_i (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.pending, .errors
	);

	always #CLK_HALF clk = ~clk;

	// overall cycle limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("radix_digit_converter_tb NOT OK");
		$finish;
	end

	// receiver stalls, mode changes every window of random length
	initial begin : receiver
		rx_mode_t mode;
		m_tready = 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(RX_OPEN, RX_MOSTLY));
			repeat ($urandom_range(16, 200)) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
					default:   m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [BASE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and hold the input side quiet for a while
	task automatic pause_sender(int unsigned gap);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_bases(logic [BASE_W-1:0] from_val, logic [BASE_W-1:0] to_val);
		pause_sender(0);
		wait_idle();
		write_reg(REG_FROM_BASE, from_val);
		write_reg(REG_TO_BASE, to_val);
		src_base = 32'((from_val < BASE_MIN) ? BASE_MIN :
			(from_val > BASE_MAX) ? BASE_MAX : from_val);
	endtask

	task automatic send_item(logic [WORD_W-1:0] din);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W-WORD_W){1'b0}}, din};
		do @(posedge clk); while (!s_tready);
	endtask

	// mostly valid source-base numbers of random magnitude, some with a bad
	// digit planted, the rest raw 60-bit noise
	function automatic logic [WORD_W-1:0] random_item(int unsigned base);
		int unsigned kind, width, n, pos;
		logic [63:0] v, rest, coded, place, scale;
		logic [3:0]  bad_d;
		bit          fits;
		kind = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (kind < 10)
			return v[WORD_W-1:0];
		width = $urandom_range(0, 64);
		if (width < 64)
			v = v & ((64'd1 << width) - 1);
		fits = 1'b0;
		coded = 0;
		while (!fits) begin
			coded = 0;
			place = 1;
			n = 0;
			rest = v;
			while (rest != 0 && n <= NUM_DEC) begin
				coded += (rest % base) * place;
				place *= 10;
				rest /= base;
				n++;
			end
			fits = (n <= NUM_DEC) && (coded <= WORD_MASK);
			if (!fits)
				v = v >> 1;
		end
		if (kind < 30 && base < BASE_MAX) begin
			if (coded >= TEN_POW_18)
				coded = coded % TEN_POW_18;
			pos = $urandom_range(0, 17);
			scale = 1;
			repeat (pos) scale *= 10;
			bad_d = 4'($urandom_range(base, 9));
			coded = coded - ((coded / scale) % 10) * scale + 64'(bad_d) * scale;
		end
		return coded[WORD_W-1:0];
	endfunction

	// stimulus and verdict
	initial begin : stimulus
		logic [BASE_W-1:0] from_plan[6];
		logic [BASE_W-1:0] to_plan[6];
		logic [BASE_W-1:0] from_val, to_val;
		int unsigned burst;
		from_plan = '{4'd2, 4'd10, 4'd2, 4'd10, 4'd0, 4'd15};
		to_plan   = '{4'd2, 4'd10, 4'd10, 4'd2, 4'd15, 4'd0};
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FROM_BASE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		src_base  = 32'(FROM_RST);
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset bases, decimal to binary: zero, exact and one-over result length,
		// nineteen-digit inputs
		send_item(60'd0);
		send_item(60'd1);
		send_item(60'd262143);
		send_item(60'd262144);
		send_item(60'd999999999999999999);
		send_item({WORD_W{1'b1}});
		send_item(60'd1000000000000000000);

		// binary to decimal, including bad digits and a nineteen-digit input
		set_bases(4'd2, 4'd10);
		send_item(60'd111111111111111111);
		send_item(60'd101);
		send_item(60'd1111111111111111111);
		send_item(60'd1000000000000000000);
		send_item(60'd12);
		send_item({WORD_W{1'b1}});

		// out-of-range bases are clamped
		set_bases(4'd0, 4'd15);
		send_item(60'd110);
		send_item(60'd2);
		set_bases(4'd15, 4'd1);
		send_item(60'd7);
		send_item(60'd987654321);

		// same base both sides
		set_bases(4'd10, 4'd10);
		send_item(60'd999999999999999999);
		send_item({WORD_W{1'b1}});
		send_item(60'd0);

		set_bases(4'd9, 4'd3);
		send_item(60'd888888888888888888);
		send_item(60'd19);
		send_item(60'd123456780);

		// random phases, extremes of the bases first
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 6) begin
				from_val = from_plan[p];
				to_val = to_plan[p];
			end else begin
				from_val = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(2, 10));
				to_val = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(2, 10));
			end
			set_bases(from_val, to_val);
			burst = $urandom_range(1, 24);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (burst == 0) begin
					pause_sender(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) :
						$urandom_range(4, 220));
					burst = $urandom_range(1, 24);
				end
				// now and then let everything drain before going on
				if ($urandom_range(0, 149) == 0) begin
					pause_sender(0);
					wait_idle();
				end
				send_item(random_item(src_base));
				burst--;
			end
		end

		pause_sender(0);
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("radix_digit_converter_tb OK");
		else
			$display("radix_digit_converter_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
